[rtl/hud_pkg.sv]
// ---------------------------------------------------------------------------
// hud_pkg: shared types and constants of the squeeze Huffman decoder
// Holds the result kind codes, the stream phase and sequencer state
// encodings, and the tree size default used by the top level and checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hud_pkg;

	localparam int unsigned NUM_VALUES_DEF = 257;

	// A tree word that reads as a leaf for the end symbol.
	localparam logic [15:0] END_LEAF   = 16'hFEFF;
	localparam logic [15:0] END_SYMBOL = 16'd256;

	typedef enum logic [2:0] {
		KIND_SYMBOL    = 3'd0,
		KIND_END       = 3'd1,
		KIND_BAD_HDR   = 3'd2,
		KIND_BAD_CHILD = 3'd3,
		KIND_TRUNC     = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_HDR_LO  = 3'd0,
		PH_HDR_HI  = 3'd1,
		PH_LOAD_LO = 3'd2,
		PH_LOAD_HI = 3'd3,
		PH_DECODE  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_EXEC  = 3'd1,
		ST_WALK  = 3'd2,
		ST_END   = 3'd3,
		ST_FLUSH = 3'd4
	} state_t;

endpackage

`default_nettype wire

[rtl/hud_ram.sv]
// ---------------------------------------------------------------------------
// hud_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// its value in cycles without a read enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hud_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 514,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/huffman_unsqueeze_decoder.sv]
// ---------------------------------------------------------------------------
// huffman_unsqueeze_decoder: squeeze Huffman stream decoder
// Parses the node count header, loads the decode tree into a RAM and walks
// it one bit per cycle when the output allows, low bit of each byte first.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one compressed byte per item, with final_byte
// marking the last byte of a stream. The output channel carries results:
// decoded symbols, the end symbol, or an error kind; run_last marks the
// last result caused by one input byte. A byte may cause no result at all.
// A header or tree-load byte passes through the exec, end and flush steps
// before the next byte is accepted. In the decode phase the walk does one
// dependent read of the tree RAM per bit, eight in all, between the issue
// and end steps; a terminal result cuts it short.
// A result waits in the holding slot until it is known whether another result
// of the same byte follows, so it appears at the latest at the flush step.
// in_stall is high while a byte is being worked on.
// When the receiver stalls, the block waits whenever a new result finds both
// the output register and the holding slot full; nothing is dropped.
// Reset clears the per-pair valid bits at once, so the tree reads as its
// reset contents immediately; there is no clearing pass over the RAM.
// A terminal result (end, error, truncation) restarts the stream state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_unsqueeze_decoder
	import hud_pkg::*;
#(
	parameter int unsigned NUM_VALUES = NUM_VALUES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      kind,
	output logic [7:0]      symbol,
	output logic            run_last
);

	localparam int unsigned PW = $clog2(NUM_VALUES);
	localparam int unsigned AW = $clog2(2 * NUM_VALUES);

	state_t           state_q, state_d;
	phase_t           phase_q;
	logic [PW-1:0]    node_count_q;
	logic [AW-1:0]    load_index_q;
	logic [7:0]       low_q;
	logic [PW-1:0]    pos_q;
	logic [NUM_VALUES-1:0] loaded_q;
	logic [2:0]       bit_q;
	logic             done_q;
	logic [7:0]       data_q;
	logic             fin_q;

	logic             rd_loaded_s, rd_pair0_s;
	logic             pend_valid_q;
	kind_t            pend_kind_q;
	logic [7:0]       pend_sym_q;
	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [7:0]       out_sym_q;
	logic             out_last_q;

	logic [15:0]      count;
	logic             hdr_bad;
	logic [AW:0]      load_nx;
	logic             load_end;
	logic [15:0]      rd_data;
	logic [15:0]      v;
	logic [15:0]      v_inv;
	logic             leaf, is_end, bad_child, term;
	logic [PW-1:0]    pos_nx;
	logic [2:0]       bit_nx;

	logic             can_push, post_ok, post_fire, push_pend;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             ram_we;
	logic             post_req;
	kind_t            post_kind;
	logic [7:0]       post_sym;
	logic             set_done, exec_go, walk_go, flush_go;

	assign count     = {data_q, low_q};
	assign hdr_bad   = count >= 16'(NUM_VALUES);
	assign load_nx   = {1'b0, load_index_q} + (AW+1)'(1);
	assign load_end  = load_nx >= {1'b0, node_count_q, 1'b0};

	// An entry of a pair that was never loaded reads as the reset tree.
	assign v         = rd_loaded_s ? rd_data : (rd_pair0_s ? END_LEAF : 16'd0);
	assign v_inv     = ~v;
	assign leaf      = v[15];
	assign is_end    = v_inv == END_SYMBOL;
	assign bad_child = v >= 16'(NUM_VALUES);
	assign term      = leaf ? is_end : bad_child;
	assign pos_nx    = leaf ? '0 : v[PW-1:0];
	assign bit_nx    = bit_q + 3'd1;

	assign can_push  = !out_valid_q || !out_stall;
	assign post_ok   = !pend_valid_q || can_push;
	assign post_fire = post_req && post_ok;
	assign push_pend = pend_valid_q && (post_fire || flush_go);
	assign ram_we    = exec_go && (phase_q == PH_LOAD_HI);

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign symbol    = out_sym_q;
	assign run_last  = out_last_q;

	hud_ram #(
		.WIDTH(16),
		.DEPTH(2 * NUM_VALUES)
	) u_tree_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(load_index_q),
		.wdata({data_q, low_q}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		post_req  = 1'b0;
		post_kind = KIND_SYMBOL;
		post_sym  = '0;
		set_done  = 1'b0;
		exec_go   = 1'b0;
		walk_go   = 1'b0;
		flush_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (phase_q == PH_HDR_HI && hdr_bad) begin
					post_req  = 1'b1;
					post_kind = KIND_BAD_HDR;
					if (post_ok) begin
						set_done = 1'b1;
						exec_go  = 1'b1;
						state_d  = ST_END;
					end
				end else begin
					exec_go = 1'b1;
					if (phase_q == PH_DECODE) begin
						rd_en   = 1'b1;
						rd_addr = {pos_q, data_q[0]};
						state_d = ST_WALK;
					end else begin
						state_d = ST_END;
					end
				end
			end
			ST_WALK: begin
				if (leaf) begin
					post_req  = 1'b1;
					post_kind = is_end ? KIND_END : KIND_SYMBOL;
					post_sym  = is_end ? 8'd0 : v_inv[7:0];
				end else if (bad_child) begin
					post_req  = 1'b1;
					post_kind = KIND_BAD_CHILD;
				end
				// The RAM holds its read data while the walk waits on the output.
				if (!post_req || post_ok) begin
					walk_go = 1'b1;
					if (term) begin
						set_done = 1'b1;
						state_d  = ST_END;
					end else if (bit_q == 3'd7) begin
						state_d = ST_END;
					end else begin
						rd_en   = 1'b1;
						rd_addr = {pos_nx, data_q[bit_nx]};
					end
				end
			end
			ST_END: begin
				if (!done_q && fin_q) begin
					post_req  = 1'b1;
					post_kind = KIND_TRUNC;
					set_done  = post_ok;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || can_push) begin
					flush_go = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR_LO;
			node_count_q <= '0;
			load_index_q <= '0;
			low_q        <= '0;
			pos_q        <= '0;
			loaded_q     <= '0;
			bit_q        <= '0;
			done_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (exec_go) begin
				unique case (phase_q)
					PH_HDR_HI: begin
						if (!hdr_bad) begin
							node_count_q <= count[PW-1:0];
							load_index_q <= '0;
							pos_q        <= '0;
							phase_q      <= (count == 16'd0) ? PH_DECODE : PH_LOAD_LO;
						end
					end
					PH_LOAD_LO: begin
						low_q   <= data_q;
						phase_q <= PH_LOAD_HI;
					end
					PH_LOAD_HI: begin
						// Writing the second word of a pair makes the pair valid.
						if (load_index_q[0]) begin
							loaded_q[load_index_q[AW-1:1]] <= 1'b1;
						end
						load_index_q <= load_nx[AW-1:0];
						if (load_end) begin
							phase_q <= PH_DECODE;
							pos_q   <= '0;
						end else begin
							phase_q <= PH_LOAD_LO;
						end
					end
					PH_DECODE: begin
						bit_q <= '0;
					end
					default: begin
						low_q   <= data_q;
						phase_q <= PH_HDR_HI;
					end
				endcase
			end
			if (walk_go) begin
				pos_q <= pos_nx;
				bit_q <= bit_nx;
			end
			if (set_done) begin
				done_q <= 1'b1;
			end
			if (post_fire) begin
				pend_valid_q <= 1'b1;
			end else if (flush_go) begin
				pend_valid_q <= 1'b0;
			end
			if (push_pend) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (flush_go && done_q) begin
				phase_q      <= PH_HDR_LO;
				node_count_q <= '0;
				load_index_q <= '0;
				low_q        <= '0;
				pos_q        <= '0;
				loaded_q     <= '0;
				done_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			data_q <= data_byte;
			fin_q  <= final_byte;
		end
		if (rd_en) begin
			rd_loaded_s <= loaded_q[rd_addr[AW-1:1]];
			rd_pair0_s  <= rd_addr[AW-1:1] == '0;
		end
		if (post_fire) begin
			pend_kind_q <= post_kind;
			pend_sym_q  <= post_sym;
		end
		if (push_pend) begin
			out_kind_q <= pend_kind_q;
			out_sym_q  <= pend_sym_q;
			out_last_q <= flush_go;
		end
	end

endmodule

`default_nettype wire

[rtl/hud_checker.sv]
// ---------------------------------------------------------------------------
// hud_assertions: port-level assertions for the squeeze Huffman decoder
// Watches the top level's channels and is attached to it by a bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hud_assertions
	import hud_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] kind,
	input wire logic [7:0] symbol,
	input wire logic       run_last
);

	// A stalled result must stay on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(symbol)
			&& $stable(run_last))
		else $error("stalled output item changed");

	// The block leaves idle on taking a byte, so it is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	// Only a decoded symbol carries a nonzero symbol value.
	a_symbol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SYMBOL |-> symbol == 8'd0)
		else $error("nonzero symbol on a non-symbol result");

	// Terminal results end the byte, so they are always the last of their run.
	a_terminal_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SYMBOL |-> run_last)
		else $error("terminal result without run_last");

endmodule

bind huffman_unsqueeze_decoder hud_assertions u_hud_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind     (kind),
	.symbol   (symbol),
	.run_last (run_last)
);

`default_nettype wire

[tb/hud_checker.sv]
// ---------------------------------------------------------------------------
// hud_checker: result predictor and scoreboard for the squeeze decoder
// Watches both channels of the decoder. Each accepted input item is run
// through a local model of the header parser, tree loader and tree walk.
// The results it predicts are queued, and every accepted result item is
// compared field by field with the oldest queued one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hud_checker
	import hud_pkg::*;
#(
	parameter int unsigned NUM_VALUES = NUM_VALUES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [2:0] kind,
	input  wire logic [7:0] symbol,
	input  wire logic       run_last,
	output int              fail_count,
	output int              pending,
	output int              byte_count,
	output int              result_count
);

	typedef struct packed {
		kind_t      code;
		logic [7:0] value;
		logic       last;
	} result_t;

	logic [15:0] tree_word [0:2*NUM_VALUES-1];
	logic        pair_valid [0:NUM_VALUES-1];
	phase_t      stream_phase;
	logic [8:0]  node_total;
	logic [9:0]  words_loaded;
	logic [7:0]  low_hold;
	logic [8:0]  walk_pos;
	result_t     expected_results [$];
	result_t     seen;
	int          errs;
	int          n_bytes;
	int          n_results;

	// A pair that was never loaded reads as end leaves at the root, zero elsewhere.
	function automatic logic [15:0] tree_entry(input logic [9:0] idx);
		if (pair_valid[idx[9:1]])
			return tree_word[idx];
		return (idx[9:1] == 9'd0) ? END_LEAF : 16'h0000;
	endfunction

	function automatic void expect_result(input kind_t c, input logic [7:0] v);
		expected_results.push_back('{code: c, value: v, last: 1'b0});
	endfunction

	task automatic restart_stream();
		for (int p = 0; p < NUM_VALUES; p++)
			pair_valid[p] = 1'b0;
		stream_phase = PH_HDR_LO;
		node_total   = '0;
		words_loaded = '0;
		low_hold     = '0;
		walk_pos     = '0;
	endtask

	task automatic unsqueeze_byte(input logic [7:0] d, input logic fin);
		int          first;
		logic        done;
		logic [15:0] count;
		logic [15:0] entry;
		logic [15:0] leaf;
		first = expected_results.size();
		done  = 1'b0;
		case (stream_phase)
		PH_HDR_HI: begin
			count = {d, low_hold};
			if (count >= NUM_VALUES) begin
				expect_result(KIND_BAD_HDR, 8'd0);
				done = 1'b1;
			end else begin
				node_total   = count[8:0];
				words_loaded = '0;
				walk_pos     = '0;
				stream_phase = (count != 16'd0) ? PH_LOAD_LO : PH_DECODE;
			end
		end
		PH_LOAD_LO: begin
			low_hold     = d;
			stream_phase = PH_LOAD_HI;
		end
		PH_LOAD_HI: begin
			if (words_loaded < 2 * NUM_VALUES) begin
				tree_word[words_loaded] = {d, low_hold};
				if (words_loaded[0])
					pair_valid[words_loaded[9:1]] = 1'b1;
			end
			words_loaded = words_loaded + 10'd1;
			if (words_loaded >= 2 * node_total) begin
				stream_phase = PH_DECODE;
				walk_pos     = '0;
			end else begin
				stream_phase = PH_LOAD_LO;
			end
		end
		PH_DECODE: begin
			for (int b = 0; b < 8 && !done; b++) begin
				entry = tree_entry({walk_pos, d[b]});
				if (entry[15]) begin
					leaf = ~entry;
					if (leaf == END_SYMBOL) begin
						expect_result(KIND_END, 8'd0);
						done = 1'b1;
					end else begin
						expect_result(KIND_SYMBOL, leaf[7:0]);
						walk_pos = '0;
					end
				end else if (entry >= NUM_VALUES) begin
					expect_result(KIND_BAD_CHILD, 8'd0);
					done = 1'b1;
				end else begin
					walk_pos = entry[8:0];
				end
			end
		end
		default: begin
			low_hold     = d;
			stream_phase = PH_HDR_HI;
		end
		endcase
		// A last byte that ended nothing on its own reports the stream as cut short.
		if (!done && fin) begin
			expect_result(KIND_TRUNC, 8'd0);
			done = 1'b1;
		end
		if (done)
			restart_stream();
		if (expected_results.size() > first)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2 * NUM_VALUES; i++)
				tree_word[i] = '0;
			tree_word[0] = END_LEAF;
			tree_word[1] = END_LEAF;
			restart_stream();
			expected_results.delete();
			errs      = 0;
			n_bytes   = 0;
			n_results = 0;
		end else begin
			if (in_valid && !in_stall) begin
				n_bytes++;
				unsqueeze_byte(data_byte, final_byte);
			end
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$error("result item with none expected: kind %0d symbol 0x%02h run_last %0b",
						kind, symbol, run_last);
					errs++;
				end else begin
					seen = expected_results.pop_front();
					if (kind !== seen.code) begin
						$error("kind: expected %0d, got %0d", seen.code, kind);
						errs++;
					end
					if (symbol !== seen.value) begin
						$error("symbol: expected 0x%02h, got 0x%02h", seen.value, symbol);
						errs++;
					end
					if (run_last !== seen.last) begin
						$error("run_last: expected %0b, got %0b", seen.last, run_last);
						errs++;
					end
				end
			end
		end
		fail_count   <= errs;
		pending      <= expected_results.size();
		byte_count   <= n_bytes;
		result_count <= n_results;
	end

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: testbench for huffman_unsqueeze_decoder
// Feeds compressed streams into the decoder: a few hand-built streams for
// the corner cases, then random streams, mostly well-formed trees with
// random data and some cut-off, oversized or garbage streams. Sender gaps
// and receiver stalls vary by phase; hud_checker judges every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
	import hud_pkg::*;
;

	localparam int RANDOM_ITEMS = 230;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte  = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [2:0] kind;
	logic [7:0] symbol;
	logic       run_last;

	int fail_count;
	int pending;
	int byte_count;
	int result_count;
	int idle_pct  = 0;
	int stall_pct = 0;
	int sent      = 0;
	int streams   = 0;

	logic [7:0] stream_bytes [$];

	huffman_unsqueeze_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.symbol     (symbol),
		.run_last   (run_last)
	);

	hud_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.final_byte   (final_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.symbol       (symbol),
		.run_last     (run_last),
		.fail_count   (fail_count),
		.pending      (pending),
		.byte_count   (byte_count),
		.result_count (result_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send_byte(input logic [7:0] d, input logic fin);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= d;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// Every stream ends on a final item, so the decoder is back at the header after it.
	task automatic send_stream();
		foreach (stream_bytes[i])
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		stream_bytes.delete();
		streams++;
	endtask

	function automatic void add_word(input logic [15:0] w);
		stream_bytes.push_back(w[7:0]);
		stream_bytes.push_back(w[15:8]);
	endfunction

	function automatic logic [15:0] random_tree_word(input int nodes);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return ~16'($urandom_range(0, 255));
		if (r < 55)
			return END_LEAF;
		if (r < 58)
			return ~16'($urandom_range(257, 32767));
		if (r < 61)
			return 16'($urandom_range(257, 32767));
		if (r < 64)
			return 16'($urandom_range(0, 256));
		return 16'($urandom_range(0, nodes - 1));
	endfunction

	task automatic random_stream();
		int sel;
		int nodes;
		int cut;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			repeat ($urandom_range(1, 5))
				stream_bytes.push_back(8'($urandom()));
		end else if (sel < 12) begin
			add_word(16'($urandom_range(257, 65535)));
		end else if (sel < 16) begin
			// A large tree is announced, but the stream stops after a few words.
			nodes = $urandom_range(64, 256);
			add_word(16'(nodes));
			repeat ($urandom_range(0, 3))
				add_word(random_tree_word(nodes));
		end else begin
			nodes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			add_word(16'(nodes));
			repeat (2 * nodes)
				add_word(random_tree_word(nodes));
			if (sel < 26) begin
				cut = $urandom_range(1, stream_bytes.size() - 1);
				repeat (cut)
					void'(stream_bytes.pop_back());
			end else begin
				repeat ($urandom_range(1, 5))
					stream_bytes.push_back(8'($urandom()));
			end
		end
		send_stream();
	endtask

	initial begin
		int base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No tree at all: the root reads as end leaves, so the first bit ends it.
		add_word(16'd0);
		stream_bytes.push_back(8'h00);
		send_stream();

		add_word(16'd257);
		send_stream();

		// One node: 'A' on a zero bit, a symbol above 256 on a one bit.
		// The last data item gives eight symbols and then the truncation.
		add_word(16'd1);
		add_word(16'hFFBE);
		add_word(16'h8000);
		stream_bytes.push_back(8'hFF);
		stream_bytes.push_back(8'h55);
		send_stream();

		// Node 0 branches to node 1 and to node 256, which is never loaded and
		// leads back to the root. Node 1 holds symbol 0 and an out-of-range child.
		add_word(16'd2);
		add_word(16'h0001);
		add_word(16'h0100);
		add_word(16'hFFFF);
		add_word(16'h7FFF);
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h01);
		stream_bytes.push_back(8'h02);
		send_stream();

		// Largest legal count, with the stream ending right on the header.
		add_word(16'd256);
		send_stream();

		base = sent;
		while (sent - base < RANDOM_ITEMS) begin
			case ((sent - base) * 4 / RANDOM_ITEMS)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 56;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 56;
			end
			default: begin
				idle_pct  = 29;
				stall_pct = 29;
			end
			endcase
			random_stream();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Fed %0d items in %0d streams; the decoder took %0d and returned %0d results.",
			sent, streams, byte_count, result_count);
		$display("Ran with no idling, sender gaps, receiver stalls, and both together.");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/hud_pkg.sv
rtl/hud_ram.sv
rtl/huffman_unsqueeze_decoder.sv
rtl/hud_checker.sv
tb/hud_checker.sv
tb/tb_top.sv
